### hw/rtl/mexp_pkg.sv
// shared constants for the modular exponentiation core
// no dependencies; used by the modular multiplier and the top level
`default_nettype none

package mexp_pkg;

  // default sizes of the exponent vector and the modulus
  localparam int EXP_BITS_DEF = 32;
  localparam int MOD_BITS_DEF = 31;

  // exponent bit count field
  localparam int LEN_W = 6;

  // status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_MOD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_EXP = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/mexp_modmul.sv
// bit-serial modular multiplier: prod = a * b mod n, one bit of b per cycle
// operands must satisfy a < n and n != 0; depends on mexp_pkg for defaults
`default_nettype none

module mexp_modmul #(
  parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] n,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);

  localparam int CNT_W = $clog2(MOD_BITS + 1);
  localparam int T_W   = MOD_BITS + 2;

  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [MOD_BITS-1:0] n_r;
  logic [CNT_W-1:0]    cnt;
  logic                running;

  logic [T_W-1:0]      t;
  logic [T_W-1:0]      n1;
  logic [T_W-1:0]      n2;
  logic [MOD_BITS-1:0] acc_next;

  // one step: acc = 2*acc + bit*a, then bring back below n (sum stays under 3n)
  always_comb begin
    t  = {1'b0, acc, 1'b0} + {2'b00, (b_r[MOD_BITS-1] ? a_r : '0)};
    n1 = {2'b00, n_r};
    n2 = {1'b0, n_r, 1'b0};
    if (t >= n2) begin
      acc_next = MOD_BITS'(t - n2);
    end else if (t >= n1) begin
      acc_next = MOD_BITS'(t - n1);
    end else begin
      acc_next = MOD_BITS'(t);
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(MOD_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      n_r <= n;
    end else if (running) begin
      acc <= acc_next;
      b_r <= b_r << 1;
    end
  end

  assign prod = acc;

  // accumulator never leaves the residue range while stepping
  assert property (@(posedge clk) disable iff (rst) running |-> (acc < n_r))
    else $error("modmul accumulator not reduced");
  // a request always starts the stepping
  assert property (@(posedge clk) disable iff (rst) go |=> running)
    else $error("modmul did not start");
  // completion only after the last step
  assert property (@(posedge clk) disable iff (rst) done |-> (!running && $past(running)))
    else $error("modmul done without a run");

endmodule

`default_nettype wire

### hw/rtl/modular_exponentiation_core.sv
// modular exponentiation core: left-to-right square-and-multiply
// the base is reduced first, then each exponent bit is tested, multiplied in when it is set
// and followed by a square (not after the last bit)
// one request at a time, set by the shared bit-serial multiplier; errors answer next cycle
// synchronous active-high reset returns the sequencer to idle; results cannot be stalled
`default_nettype none

module modular_exponentiation_core #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
  parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [MOD_BITS-1:0]           base,
  input  logic [EXP_BITS-1:0]           exponent_bits,
  input  logic [mexp_pkg::LEN_W-1:0]    exponent_length,
  input  logic [MOD_BITS-1:0]           modulus,
  output logic                          done,
  output logic [MOD_BITS-1:0]           power,
  output logic [mexp_pkg::STATUS_W-1:0] status
);

  import mexp_pkg::*;

  localparam int CW  = $clog2(EXP_BITS + 1);
  localparam int L7W = LEN_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_RED, S_BIT, S_MUL, S_SQR} state_t;

  state_t              state;
  logic [EXP_BITS-1:0] exp_r;
  logic [CW-1:0]       cnt;
  logic [MOD_BITS-1:0] s;
  logic [MOD_BITS-1:0] y;
  logic [MOD_BITS-1:0] n_r;
  logic [MOD_BITS-1:0] op_a;
  logic [MOD_BITS-1:0] op_b;
  logic                mm_go;
  logic                mm_done;
  logic [MOD_BITS-1:0] mm_prod;

  logic [L7W-1:0]      len_ext;
  logic [L7W-1:0]      len_eff;
  logic [L7W-1:0]      shamt;
  logic [MOD_BITS-1:0] s0;

  // bit count saturates at the exponent width; first bit goes to the top
  always_comb begin
    len_ext = {1'b0, exponent_length};
    len_eff = (len_ext > L7W'(EXP_BITS)) ? L7W'(EXP_BITS) : len_ext;
    shamt   = L7W'(EXP_BITS) - len_eff;
    s0      = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  end

  assign busy = (state != S_IDLE);

  mexp_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .a    (op_a),
    .b    (op_b),
    .n    (n_r),
    .done (mm_done),
    .prod (mm_prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      mm_go <= 1'b0;
    end else begin
      done  <= 1'b0;
      mm_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (modulus == '0) begin
              done   <= 1'b1;
              power  <= '0;
              status <= ST_ZERO_MOD;
            end else if (exponent_length == '0) begin
              done   <= 1'b1;
              power  <= '0;
              status <= ST_EMPTY_EXP;
            end else begin
              // reduce the base first: base * (1 mod n)
              n_r   <= modulus;
              s     <= s0;
              exp_r <= exponent_bits << shamt;
              cnt   <= CW'(len_eff);
              op_a  <= s0;
              op_b  <= base;
              mm_go <= 1'b1;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_done) begin
            y     <= mm_prod;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          exp_r <= exp_r << 1;
          if (exp_r[EXP_BITS-1]) begin
            op_a  <= s;
            op_b  <= y;
            mm_go <= 1'b1;
            state <= S_MUL;
          end else if (cnt == CW'(1)) begin
            done   <= 1'b1;
            power  <= s;
            status <= ST_OK;
            state  <= S_IDLE;
          end else begin
            op_a  <= s;
            op_b  <= s;
            mm_go <= 1'b1;
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_done) begin
            if (cnt == CW'(1)) begin
              done   <= 1'b1;
              power  <= mm_prod;
              status <= ST_OK;
              state  <= S_IDLE;
            end else begin
              op_a  <= mm_prod;
              op_b  <= mm_prod;
              mm_go <= 1'b1;
              state <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mm_done) begin
            s     <= mm_prod;
            cnt   <= cnt - 1'b1;
            state <= S_BIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // multiplier completions only arrive while a multiply is awaited
  assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("unexpected multiplier completion");
  // an error result always carries a zero power
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (power == '0))
    else $error("error result with nonzero power");
  // a zero modulus is answered on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && modulus == '0) |=> (done && status == ST_ZERO_MOD))
    else $error("zero modulus not reported");
  // results come out with the sequencer back in idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

endmodule

`default_nettype wire
